// File: sv/csc_pkg.sv
// shared types, codes and constants of the csv syntax checker
package csc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_DQ  = 8'd34;

    localparam logic [7:0] SEP_RESET = 8'd44;

    localparam logic [7:0] CFG_FIELD_SEPARATOR      = 8'd0;
    localparam logic [7:0] CFG_QUOTES_SPECIAL       = 8'd1;
    localparam logic [7:0] CFG_NEWLINE_IN_QUOTES_OK = 8'd2;

    localparam logic [2:0] EV_CONSUMED     = 3'd0;
    localparam logic [2:0] EV_FIELD_END    = 3'd1;
    localparam logic [2:0] EV_RECORD_END   = 3'd2;
    localparam logic [2:0] EV_STREAM_END   = 3'd3;
    localparam logic [2:0] EV_BAD_QUOTE    = 3'd4;
    localparam logic [2:0] EV_EMBEDDED_NL  = 3'd5;
    localparam logic [2:0] EV_UNTERMINATED = 3'd6;
    localparam logic [2:0] EV_AFTER_ERROR  = 3'd7;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_CR,
        CLS_NL,
        CLS_QUOTE,
        CLS_SEP,
        CLS_OTHER
    } byte_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [31:0] line_number;
        logic [15:0] field_count;
        logic [7:0]  field_byte;
        logic        field_byte_valid;
    } out_item_t;

    typedef struct packed {
        byte_class_t cls;
        logic        nl_ok;
        logic [7:0]  data_byte;
    } cls_item_t;

endpackage

// File: sv/csc_front.sv
// front end: configuration registers and byte classification
module csc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  csc_pkg::in_item_t   in_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                q_full,
    output logic                q_wr,
    output csc_pkg::cls_item_t  q_wr_item
);
    import csc_pkg::*;

    logic [7:0] sep_reg;
    logic       quotes_reg;
    logic       nl_ok_reg;
    logic       is_end;
    logic       is_quote;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg    <= SEP_RESET;
            quotes_reg <= 1'b1;
            nl_ok_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIELD_SEPARATOR:      sep_reg    <= cfg_data;
                CFG_QUOTES_SPECIAL:       quotes_reg <= cfg_data[0];
                CFG_NEWLINE_IN_QUOTES_OK: nl_ok_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign is_end   = in_item.end_of_input || (in_item.data_byte == CH_NUL);
    assign is_quote = (in_item.data_byte == CH_DQ) && quotes_reg;

    always_comb
    begin
        if (is_end)
            q_wr_item.cls = CLS_END;
        else if (in_item.data_byte == CH_CR)
            q_wr_item.cls = CLS_CR;
        else if (in_item.data_byte == CH_NL)
            q_wr_item.cls = CLS_NL;
        else if (is_quote)
            q_wr_item.cls = CLS_QUOTE;
        else if (in_item.data_byte == sep_reg)
            q_wr_item.cls = CLS_SEP;
        else
            q_wr_item.cls = CLS_OTHER;
        q_wr_item.nl_ok     = nl_ok_reg;
        q_wr_item.data_byte = in_item.data_byte;
    end

    assign full = q_full;
    assign q_wr = push && !q_full;

endmodule

// File: sv/csc_queue.sv
// short queue of classified bytes between front and back
module csc_queue #(
    parameter int DEPTH = csc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  csc_pkg::cls_item_t  wr_item,
    output logic                q_full,
    input  logic                rd,
    output csc_pkg::cls_item_t  rd_item,
    output logic                q_empty
);
    import csc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");
`endif

endmodule

// File: sv/csc_back.sv
// back end: parse state machine, counters and result register
module csc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  csc_pkg::cls_item_t  q_item,
    output logic                q_rd,
    output csc_pkg::out_item_t  out_item,
    output logic                empty,
    input  logic                pop
);
    import csc_pkg::*;

    typedef enum logic [2:0] {
        ST_REC_START,
        ST_FIELD_START,
        ST_IN_FIELD,
        ST_IN_QUOTED,
        ST_QUOTE_SEEN,
        ST_ERROR,
        ST_DONE
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] line_reg;
    logic [31:0] line_next;
    logic [15:0] fields_reg;
    logic [15:0] fields_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_reg;
    out_item_t   out_next;

    logic        take;
    logic [2:0]  ev;
    logic        fbv;
    logic        bump_l;
    logic        bump_f;
    logic        close_rec;
    logic [31:0] line_sat;
    logic [15:0] fields_sat;
    logic [15:0] fc;

    assign take = !q_empty && (!out_valid_reg || pop);
    assign q_rd = take;

    assign line_sat   = (line_reg == 32'hFFFF_FFFF) ? line_reg : line_reg + 32'd1;
    assign fields_sat = (fields_reg == 16'hFFFF) ? fields_reg : fields_reg + 16'd1;

    always_comb
    begin
        ev         = EV_CONSUMED;
        fbv        = 1'b0;
        bump_l     = 1'b0;
        bump_f     = 1'b0;
        close_rec  = 1'b0;
        state_next = state_reg;
        if (state_reg == ST_ERROR)
            ev = EV_AFTER_ERROR;
        else if (state_reg == ST_DONE)
            ev = EV_STREAM_END;
        else if (q_item.cls == CLS_END)
        begin
            if (state_reg == ST_IN_QUOTED)
            begin
                ev         = EV_UNTERMINATED;
                state_next = ST_ERROR;
            end
            else
            begin
                bump_f     = (state_reg != ST_REC_START);
                ev         = EV_STREAM_END;
                close_rec  = 1'b1;
                state_next = ST_DONE;
            end
        end
        else if (q_item.cls == CLS_CR)
            ev = EV_CONSUMED;
        else if (state_reg == ST_IN_QUOTED)
        begin
            if (q_item.cls == CLS_QUOTE)
                state_next = ST_QUOTE_SEEN;
            else if (q_item.cls == CLS_NL)
            begin
                bump_l = 1'b1;
                if (q_item.nl_ok)
                    fbv = 1'b1;
                else
                begin
                    ev         = EV_EMBEDDED_NL;
                    state_next = ST_ERROR;
                end
            end
            else
                fbv = 1'b1;
        end
        else if (q_item.cls == CLS_NL)
        begin
            bump_l     = 1'b1;
            bump_f     = (state_reg != ST_REC_START);
            ev         = EV_RECORD_END;
            close_rec  = 1'b1;
            state_next = ST_REC_START;
        end
        else
        begin
            unique case (state_reg)
                ST_QUOTE_SEEN:
                begin
                    if (q_item.cls == CLS_QUOTE)
                    begin
                        fbv        = 1'b1;
                        state_next = ST_IN_QUOTED;
                    end
                    else if (q_item.cls == CLS_SEP)
                    begin
                        bump_f     = 1'b1;
                        ev         = EV_FIELD_END;
                        state_next = ST_FIELD_START;
                    end
                    else
                    begin
                        ev         = EV_BAD_QUOTE;
                        state_next = ST_ERROR;
                    end
                end
                ST_IN_FIELD:
                begin
                    if (q_item.cls == CLS_QUOTE)
                    begin
                        ev         = EV_BAD_QUOTE;
                        state_next = ST_ERROR;
                    end
                    else if (q_item.cls == CLS_SEP)
                    begin
                        bump_f     = 1'b1;
                        ev         = EV_FIELD_END;
                        state_next = ST_FIELD_START;
                    end
                    else
                        fbv = 1'b1;
                end
                default:
                begin
                    // record start or field start
                    if (q_item.cls == CLS_QUOTE)
                        state_next = ST_IN_QUOTED;
                    else if (q_item.cls == CLS_SEP)
                    begin
                        bump_f     = 1'b1;
                        ev         = EV_FIELD_END;
                        state_next = ST_FIELD_START;
                    end
                    else
                    begin
                        fbv        = 1'b1;
                        state_next = ST_IN_FIELD;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        fc          = bump_f ? fields_sat : fields_reg;
        line_next   = bump_l ? line_sat : line_reg;
        fields_next = close_rec ? 16'd0 : fc;

        out_next.event_code       = ev;
        out_next.line_number      = line_next;
        out_next.field_count      = fc;
        out_next.field_byte       = fbv ? q_item.data_byte : 8'd0;
        out_next.field_byte_valid = fbv;

        if (take)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_REC_START;
            line_reg      <= 32'd1;
            fields_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg  <= state_next;
                line_reg   <= line_next;
                fields_reg <= fields_next;
                out_reg    <= out_next;
            end
        end
    end

    assign out_item = out_reg;
    assign empty    = !out_valid_reg;

`ifndef ASSERT_OFF
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERROR) |=> (state_reg == ST_ERROR))
        else $error("error state left");

    a_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (take && state_reg == ST_ERROR) |=> (out_reg.event_code == EV_AFTER_ERROR))
        else $error("transaction after error not flagged");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 32'd0)
        else $error("line counter wrapped");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result overwritten");
`endif

endmodule

// File: sv/csv_syntax_checker_unit.sv
// top level of the csv syntax checker
// Checks CSV text one byte per transaction and returns one result per byte: consumed,
// field end, record end, stream end or a sticky error, with the line number, the
// field count of the current record and the unescaped content byte. Sustained rate is
// one byte per cycle while results are popped; a pushed byte is written into the queue,
// then taken by the parse state machine into the result register, from which it is
// popped. The rate is set by the parse state machine in the back end, fed from a
// short queue of classified bytes (QUEUE_DEPTH entries) that absorbs result stalls.
// Configuration writes take effect on bytes pushed afterwards; write only while idle.
module csv_syntax_checker_unit #(
    parameter int QUEUE_DEPTH = csc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  csc_pkg::in_item_t   in_item,
    output logic                empty,
    input  logic                pop,
    output csc_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import csc_pkg::*;

    logic      q_full;
    logic      q_empty;
    logic      q_wr;
    logic      q_rd;
    cls_item_t q_wr_item;
    cls_item_t q_rd_item;

    csc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wr_item (q_wr_item)
    );

    csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (q_wr_item),
        .q_full  (q_full),
        .rd      (q_rd),
        .rd_item (q_rd_item),
        .q_empty (q_empty)
    );

    csc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .q_rd     (q_rd),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
